// ===== src/assert_macros.svh =====
// Assertion macros for the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TCCW_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define TCCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define TCCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tccw_pkg.sv =====
// Shared constants, types and helpers of the text console writer.
`timescale 1ns / 1ps
package tccw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 24;
  localparam int TAB_WIDTH     = 4;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

  // Field widths of the channels.
  localparam int CHAR_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int CELL_W   = 16;
  localparam int COL_W    = 7;
  localparam int LINE_W   = 5;
  localparam int COLOUR_W = 4;

  localparam int MEM_AW = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(SCREEN_WIDTH);

  // Configuration port geometry.
  localparam int REG_COUNT = 2;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = $clog2(REG_COUNT * 4);
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_FG = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_BG = REG_IDX_W'(1);

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;

  localparam logic [COLOUR_W-1:0] FG_RESET = 4'd15;
  localparam logic [COLOUR_W-1:0] BG_RESET = 4'd0;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_TAB,
    S_CLEAR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [COLOUR_W-1:0] bg;
    logic [COLOUR_W-1:0] fg;
  } colours_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [MEM_AW-1:0] addr;
    logic [CELL_W-1:0] wdata;
  } ram_req_t;

  function automatic logic [CELL_W-1:0] make_cell(input colours_t col,
                                                  input logic [CHAR_W-1:0] ch);
    make_cell = {col.bg, col.fg, ch};
  endfunction

endpackage

// ===== src/tccw_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface tccw_in_if import tccw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] cell_address;

  modport source (output valid, op, char_code, cell_address, input ready);
  modport sink (input valid, op, char_code, cell_address, output ready);
endinterface

interface tccw_out_if import tccw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] read_data;
  logic [COL_W-1:0]  cursor_column;
  logic [LINE_W-1:0] cursor_line;
  logic              scrolled;

  modport source (output valid, read_data, cursor_column, cursor_line, scrolled,
                  input ready);
  modport sink (input valid, read_data, cursor_column, cursor_line, scrolled,
                output ready);
endinterface

// ===== src/tccw_screen_ram.sv =====
// Single-port screen cell memory with registered read data.
`timescale 1ns / 1ps
module tccw_screen_ram import tccw_pkg::*; (
  input  logic              clk_i,
  input  ram_req_t          req_i,
  output logic [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tccw_cfg_regs.sv =====
// Colour registers behind the APB-style configuration port.
`timescale 1ns / 1ps
module tccw_cfg_regs import tccw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output colours_t           colours_o
);

  colours_t              colours_q, colours_d;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic [COLOUR_W-1:0]   rd_val;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    colours_d = colours_q;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_FG: colours_d.fg = pwdata[COLOUR_W-1:0];
        REG_BG: colours_d.bg = pwdata[COLOUR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FG: rd_val = colours_q.fg;
      REG_BG: rd_val = colours_q.bg;
    endcase
  end

  assign prdata = DATA_W'(rd_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colours_q.fg <= FG_RESET;
      colours_q.bg <= BG_RESET;
    end else begin
      colours_q <= colours_d;
    end
  end

  assign colours_o = colours_q;

endmodule

// ===== src/text_console_character_writer.sv =====
// Top level of the text console writer: cursor logic and screen sequencer.
//
//   Channel  Direction  Carries
//   in_i     sink       op, char_code, cell_address
//   out_o    source     read_data, cursor_column, cursor_line, scrolled
//   APB      slave      foreground colour (0x0), background colour (0x4)
//
// A read, a printable byte or a newline goes from S_IDLE to S_DONE; a tab that fits
// first writes TAB_WIDTH blank cells in S_TAB. A scroll adds S_CLEAR, which clears
// the new bottom line, one memory write per cycle. Scrolling moves a line offset,
// not the cells. After reset S_INIT clears all CELL_COUNT (1920) cells before any item.
// The result register lets a new item in while a result waits; a stalled result
// holds the sequencer in its final state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module text_console_character_writer import tccw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  tccw_in_if.sink            in_i,
  tccw_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam logic [MEM_AW:0] CELLS_X = (MEM_AW + 1)'(CELL_COUNT);

  state_e              state_q, state_d;
  logic [COL_W-1:0]    cur_x_q, cur_x_d;
  logic [LINE_W-1:0]   cur_y_q, cur_y_d;
  logic [MEM_AW-1:0]   cur_phys_q, cur_phys_d;
  logic [MEM_AW-1:0]   base_q, base_d;
  logic [MEM_AW-1:0]   sweep_q, sweep_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                is_read_q, is_read_d;
  logic                rd_ok_q, rd_ok_d;
  logic                scrolled_q, scrolled_d;
  logic                out_valid_q, out_valid_d;
  logic [CELL_W-1:0]   out_data_q;
  logic [COL_W-1:0]    out_x_q;
  logic [LINE_W-1:0]   out_y_q;
  logic                out_scr_q;

  colours_t            colours;
  ram_req_t            ram_req;
  logic [CELL_W-1:0]   ram_rdata;

  logic                in_acc, out_free, load_out;
  logic                is_nl, is_tab, is_print, tab_fits, x_wrap;
  logic                new_line, line_adv, scroll, rd_ok;
  logic [COL_W:0]      x_inc, x_tab;
  logic [LINE_W:0]     y_inc;
  logic [MEM_AW-1:0]   row_start, phys_next_line, base_next, rd_phys;
  logic [MEM_AW:0]     nl_sum, base_sum, rd_sum;
  logic [CELL_W-1:0]   blank;
  logic [31:0]         cur_lin;

  tccw_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .colours_o (colours)
  );

  tccw_screen_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign is_nl    = (in_i.char_code == CODE_NEWLINE);
  assign is_tab   = (in_i.char_code == CODE_TAB);
  assign is_print = !is_nl && !is_tab;

  assign x_inc    = {1'b0, cur_x_q} + (COL_W + 1)'(1);
  assign x_wrap   = (x_inc == (COL_W + 1)'(SCREEN_WIDTH));
  assign x_tab    = {1'b0, cur_x_q} + (COL_W + 1)'(TAB_WIDTH);
  assign tab_fits = (x_tab < (COL_W + 1)'(SCREEN_WIDTH));
  assign y_inc    = {1'b0, cur_y_q} + (LINE_W + 1)'(1);

  assign new_line = is_nl || (is_tab && !tab_fits);
  assign line_adv = new_line || (is_print && x_wrap);
  assign scroll   = line_adv && (y_inc == (LINE_W + 1)'(SCREEN_HEIGHT));

  // Lines are contiguous in memory, so the next line starts one width on,
  // wrapping round the top of the store.
  assign row_start      = cur_phys_q - MEM_AW'(cur_x_q);
  assign nl_sum         = {1'b0, row_start} + (MEM_AW + 1)'(SCREEN_WIDTH);
  assign phys_next_line = (nl_sum >= CELLS_X) ? MEM_AW'(nl_sum - CELLS_X)
                                              : nl_sum[MEM_AW-1:0];
  assign base_sum       = {1'b0, base_q} + (MEM_AW + 1)'(SCREEN_WIDTH);
  assign base_next      = (base_sum >= CELLS_X) ? MEM_AW'(base_sum - CELLS_X)
                                                : base_sum[MEM_AW-1:0];

  assign rd_ok   = (in_i.cell_address < ADDR_W'(CELL_COUNT));
  assign rd_sum  = (MEM_AW + 1)'(in_i.cell_address) + {1'b0, base_q};
  assign rd_phys = (rd_sum >= CELLS_X) ? MEM_AW'(rd_sum - CELLS_X)
                                       : rd_sum[MEM_AW-1:0];

  assign blank = make_cell(colours, CODE_SPACE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (sweep_q == MEM_AW'(CELL_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.op == OP_READ) begin
            state_d = S_DONE;
          end else if (is_tab && tab_fits) begin
            state_d = S_TAB;
          end else if (scroll) begin
            state_d = S_CLEAR;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_TAB: begin
        if (cnt_q == CNT_W'(TAB_WIDTH - 1)) begin
          state_d = S_DONE;
        end
      end
      S_CLEAR: begin
        if (cnt_q == CNT_W'(SCREEN_WIDTH - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  // Memory requests, cursor updates and result loading.
  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    cur_phys_d = cur_phys_q;
    base_d     = base_q;
    sweep_d    = sweep_q;
    cnt_d      = cnt_q;
    is_read_d  = is_read_q;
    rd_ok_d    = rd_ok_q;
    scrolled_d = scrolled_q;
    ram_req    = '0;
    load_out   = 1'b0;

    unique case (state_q)
      S_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = sweep_q;
        ram_req.wdata = make_cell('{bg: BG_RESET, fg: FG_RESET}, CODE_SPACE);
        sweep_d       = sweep_q + MEM_AW'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          is_read_d  = (in_i.op == OP_READ);
          rd_ok_d    = rd_ok;
          scrolled_d = 1'b0;
          if (in_i.op == OP_READ) begin
            ram_req.re   = rd_ok;
            ram_req.addr = rd_phys;
          end else begin
            if (is_print) begin
              ram_req.we    = 1'b1;
              ram_req.addr  = cur_phys_q;
              ram_req.wdata = make_cell(colours, in_i.char_code);
            end
            if (is_tab && tab_fits) begin
              sweep_d    = cur_phys_q;
              cnt_d      = '0;
              cur_x_d    = x_tab[COL_W-1:0];
              cur_phys_d = cur_phys_q + MEM_AW'(TAB_WIDTH);
            end else if (scroll) begin
              // The old top line becomes the new bottom line.
              sweep_d    = base_q;
              cnt_d      = '0;
              cur_x_d    = '0;
              cur_y_d    = LINE_W'(SCREEN_HEIGHT - 1);
              cur_phys_d = base_q;
              base_d     = base_next;
              scrolled_d = 1'b1;
            end else if (line_adv) begin
              cur_x_d    = '0;
              cur_y_d    = y_inc[LINE_W-1:0];
              cur_phys_d = phys_next_line;
            end else begin
              cur_x_d    = x_inc[COL_W-1:0];
              cur_phys_d = cur_phys_q + MEM_AW'(1);
            end
          end
        end
      end
      S_TAB, S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = sweep_q;
        ram_req.wdata = blank;
        sweep_d       = sweep_q + MEM_AW'(1);
        cnt_d         = cnt_q + CNT_W'(1);
      end
      S_DONE: begin
        load_out = out_free;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_phys_q  <= '0;
      base_q      <= '0;
      sweep_q     <= '0;
      cnt_q       <= '0;
      is_read_q   <= 1'b0;
      rd_ok_q     <= 1'b0;
      scrolled_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      cur_phys_q  <= cur_phys_d;
      base_q      <= base_d;
      sweep_q     <= sweep_d;
      cnt_q       <= cnt_d;
      is_read_q   <= is_read_d;
      rd_ok_q     <= rd_ok_d;
      scrolled_q  <= scrolled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= (is_read_q && rd_ok_q) ? ram_rdata : '0;
      out_x_q    <= cur_x_q;
      out_y_q    <= cur_y_q;
      out_scr_q  <= scrolled_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = out_data_q;
  assign out_o.cursor_column = out_x_q;
  assign out_o.cursor_line   = out_y_q;
  assign out_o.scrolled      = out_scr_q;

  // Logical cursor position shifted by the line offset, for checking only.
  assign cur_lin = 32'(cur_y_q) * 32'(SCREEN_WIDTH) + 32'(cur_x_q) + 32'(base_q);

  `TCCW_ASSERT(a_cursor_on_screen, (cur_x_q < COL_W'(SCREEN_WIDTH)) && (cur_y_q < LINE_W'(SCREEN_HEIGHT)), "cursor left the screen")
  `TCCW_ASSERT_IMP(a_phys_tracks_cursor, state_q == S_IDLE, (cur_lin == 32'(cur_phys_q)) || (cur_lin == 32'(cur_phys_q) + 32'(CELL_COUNT)), "cursor memory address out of step")
  `TCCW_ASSERT_IMP(a_scroll_cursor, out_o.valid && out_o.scrolled, (out_o.cursor_column == '0) && (out_o.cursor_line == LINE_W'(SCREEN_HEIGHT - 1)), "scroll left cursor off the bottom line start")
  `TCCW_ASSERT_NXT(a_one_item_at_a_time, in_acc, !in_i.ready, "second item taken while one is at work")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench of the text console writer: cursor, tabs, wraps, scrolls and reads.
`timescale 1ns / 1ps
module tb_top;
  import tccw_pkg::*;

  localparam int IDLE_PCT      = 14;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = SCREEN_WIDTH + TAB_WIDTH + 16;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [COL_W-1:0]  column;
    logic [LINE_W-1:0] line;
    logic              scrolled;
  } console_status_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  tccw_in_if  in_ch ();
  tccw_out_if out_ch ();

  text_console_character_writer DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the screen, the cursor and the colour registers.
  logic [CELL_W-1:0]   shadow_screen [CELL_COUNT];
  int                  cur_col;
  int                  cur_line;
  logic [COLOUR_W-1:0] fg_colour;
  logic [COLOUR_W-1:0] bg_colour;

  console_status_t awaited_status [$];

  int errors;
  int cycle_count;
  int n_puts;
  int n_tabs;
  int n_newlines;
  int n_reads;
  int n_scrolls;
  int n_colour_writes;
  bit steady;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
             awaited_status.size());
    $display("tb_top: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic logic [CELL_W-1:0] coloured_cell(input logic [CHAR_W-1:0] ch);
    return {bg_colour, fg_colour, ch};
  endfunction

  function automatic logic [CHAR_W-1:0] random_glyph();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255));
    while (c == CODE_TAB || c == CODE_NEWLINE);
    return c;
  endfunction

  // Applies one accepted item to the shadow state and returns the status it should report.
  function automatic console_status_t apply_item(input logic op, input logic [CHAR_W-1:0] ch,
                                                 input logic [ADDR_W-1:0] addr);
    console_status_t st;
    int pos;
    int k;
    st = '0;
    if (op == OP_READ) begin
      n_reads++;
      if (addr < CELL_COUNT) st.cell_data = shadow_screen[addr];
    end else begin
      n_puts++;
      pos = cur_line * SCREEN_WIDTH + cur_col;
      if (ch == CODE_NEWLINE) begin
        n_newlines++;
        cur_col = 0;
        cur_line++;
      end else if (ch == CODE_TAB) begin
        n_tabs++;
        if (cur_col + TAB_WIDTH < SCREEN_WIDTH) begin
          for (k = 0; k < TAB_WIDTH; k++) shadow_screen[pos + k] = coloured_cell(CODE_SPACE);
          cur_col += TAB_WIDTH;
        end else begin
          // A tab that does not fit behaves exactly like a newline.
          cur_col = 0;
          cur_line++;
        end
      end else begin
        shadow_screen[pos] = coloured_cell(ch);
        cur_col++;
        if (cur_col >= SCREEN_WIDTH) begin
          cur_col = 0;
          cur_line++;
        end
      end
      if (cur_line >= SCREEN_HEIGHT) begin
        for (k = 0; k < CELL_COUNT - SCREEN_WIDTH; k++)
          shadow_screen[k] = shadow_screen[k + SCREEN_WIDTH];
        for (k = CELL_COUNT - SCREEN_WIDTH; k < CELL_COUNT; k++)
          shadow_screen[k] = coloured_cell(CODE_SPACE);
        cur_col = 0;
        cur_line = SCREEN_HEIGHT - 1;
        st.scrolled = 1'b1;
        n_scrolls++;
      end
    end
    st.column = COL_W'(cur_col);
    st.line = LINE_W'(cur_line);
    return st;
  endfunction

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      if (errors < 40)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    console_status_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (awaited_status.size() == 0) begin
        if (errors < 40)
          $display("%0t: unexpected result, expected none, got cell 0x%0h col %0d line %0d",
                   $time, out_ch.read_data, out_ch.cursor_column, out_ch.cursor_line);
        errors++;
      end else begin
        want = awaited_status.pop_front();
        report_field("read_data", want.cell_data, out_ch.read_data);
        report_field("cursor_column", want.column, out_ch.cursor_column);
        report_field("cursor_line", want.line, out_ch.cursor_line);
        report_field("scrolled", want.scrolled, out_ch.scrolled);
      end
    end
  end

  // Valid stays high from one item to the next unless a gap is chosen.
  task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                           input logic [ADDR_W-1:0] addr);
    int gap;
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.char_code <= ch;
    in_ch.cell_address <= addr;
    do @(posedge clk_i);
    while (!in_ch.ready);
    awaited_status.push_back(apply_item(op, ch, addr));
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(OP_PUT, ch, ADDR_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input int addr);
    send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), ADDR_W'(addr));
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes a colour register, then reads it back in a back-to-back transfer.
  task automatic write_colour(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (idx == REG_FG) fg_colour = value[COLOUR_W-1:0];
    else bg_colour = value[COLOUR_W-1:0];
    n_colour_writes++;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    report_field("prdata", DATA_W'(value[COLOUR_W-1:0]), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_screen();
    read_cell(0);
    read_cell(2047);
    read_cell(CELL_COUNT - 1);
    read_cell(CELL_COUNT);
    read_cell(1000);
  endtask

  task automatic test_put_codes();
    int k;
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CODE_SPACE);
    put_char(8'h41);
    put_char(CODE_TAB);
    put_char(CODE_NEWLINE);
    for (k = 0; k < 5; k++) read_cell(k);
  endtask

  task automatic test_colour_registers();
    quiesce();
    write_colour(REG_FG, '0);
    write_colour(REG_BG, 32'hF);
    put_char(8'h5A);
    put_char(CODE_TAB);
    read_cell(SCREEN_WIDTH);
    read_cell(SCREEN_WIDTH + 3);
  endtask

  task automatic test_tab_to_line_end();
    int line_base;
    line_base = cur_line * SCREEN_WIDTH;
    while (cur_col + TAB_WIDTH < SCREEN_WIDTH) put_char(CODE_TAB);
    put_char(CODE_TAB);
    read_cell(line_base + SCREEN_WIDTH - TAB_WIDTH - 1);
    read_cell(line_base + SCREEN_WIDTH - 1);
  endtask

  task automatic test_line_wrap();
    int line_base;
    line_base = cur_line * SCREEN_WIDTH;
    put_char(random_glyph());
    while (cur_col != 0) put_char(random_glyph());
    put_char(random_glyph());
    read_cell(line_base);
    read_cell(line_base + SCREEN_WIDTH - 1);
    read_cell(line_base + SCREEN_WIDTH);
  endtask

  task automatic test_scroll();
    int k;
    while (cur_line != SCREEN_HEIGHT - 1) put_char(CODE_NEWLINE);
    for (k = 0; k < 3; k++) put_char(random_glyph());
    put_char(CODE_NEWLINE);
    for (k = 0; k < 3; k++) read_cell(CELL_COUNT - 2 * SCREEN_WIDTH + k);
    read_cell(CELL_COUNT - SCREEN_WIDTH);
    read_cell(0);
    // Wrapping off the last line scrolls as well.
    while (cur_col + TAB_WIDTH < SCREEN_WIDTH) put_char(CODE_TAB);
    while (cur_col != SCREEN_WIDTH - 1) put_char(random_glyph());
    put_char(random_glyph());
    read_cell(CELL_COUNT - SCREEN_WIDTH - 1);
  endtask

  // Mostly text with some newlines and tabs; reads favour the cursor's own region.
  task automatic test_random_traffic(input int count);
    int i;
    int r;
    int base;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) put_char(CHAR_W'($urandom_range(0, 255)));
      else if (r < 66) put_char(CODE_NEWLINE);
      else if (r < 76) put_char(CODE_TAB);
      else begin
        r = $urandom_range(0, 99);
        base = (cur_line > 0 && $urandom_range(0, 1) == 1) ? cur_line - 1 : cur_line;
        if (r < 50) read_cell(base * SCREEN_WIDTH + $urandom_range(0, SCREEN_WIDTH - 1));
        else if (r < 85) read_cell($urandom_range(0, CELL_COUNT - 1));
        else read_cell($urandom_range(CELL_COUNT, 2047));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_PUT;
    in_ch.char_code = '0;
    in_ch.cell_address = '0;
    cycle_count = 0;
    errors = 0;
    steady = 1'b0;
    cur_col = 0;
    cur_line = 0;
    fg_colour = FG_RESET;
    bg_colour = BG_RESET;
    for (int k = 0; k < CELL_COUNT; k++) shadow_screen[k] = coloured_cell(CODE_SPACE);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_screen();
    test_put_codes();
    test_colour_registers();
    test_tab_to_line_end();
    test_line_wrap();
    test_scroll();

    quiesce();
    write_colour(REG_FG, $urandom);
    write_colour(REG_BG, $urandom);
    test_random_traffic(125);

    quiesce();
    steady = 1'b1;
    // Upper data bits are set to show that only the low nibble is kept.
    write_colour(REG_FG, 32'hFFFF_FFFF);
    write_colour(REG_BG, 32'hFFFF_FFF0);
    test_random_traffic(125);

    quiesce();
    steady = 1'b0;
    write_colour(REG_FG, $urandom);
    write_colour(REG_BG, $urandom);
    test_random_traffic(125);

    in_ch.valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb_top: %0d puts (%0d tabs, %0d newlines) and %0d reads, %0d scrolls",
             n_puts, n_tabs, n_newlines, n_reads, n_scrolls);
    $display("tb_top: %0d colour register writes, %0d mismatches", n_colour_writes, errors);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
